[src/fbv_pkg.sv]
// Shared types and constants of the FM bass voice: microcode word, status group,
// register indexes, and the quarter-wave sine table built at elaboration.
// No dependencies.
`default_nettype none

package fbv_pkg;

    // Sine table geometry
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned SINE_IDX_W      = SINE_TABLE_BITS - 2;
    localparam int unsigned QUARTER_SIZE    = 1 << SINE_IDX_W;
    localparam int unsigned MOD_RATIO       = 2;

    localparam logic [23:0] ENV_ONE     = 24'h800000;
    localparam logic [31:0] STEP_55HZ   = 32'd5356535;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_INDEX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL    = 3'd6;

    // Microcode
    localparam int unsigned PC_W = 4;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_SILENT   = 3'd2,
        COND_ATTACK   = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    typedef enum logic [2:0] {
        MUL_NONE      = 3'd0,
        MUL_AGE_STEP  = 3'd1,
        MUL_DECAY     = 3'd2,
        MUL_SIN_INDEX = 3'd3,
        MUL_PROD_ENV  = 3'd4,
        MUL_SIN_VOL   = 3'd5
    } mul_sel_t;

    typedef struct packed {
        cond_t           cond;
        logic [PC_W-1:0] target;
        mul_sel_t        mul_sel;
        logic            adv_phase;
        logic            env_from_prod;
        logic            env_from_decay;
        logic            decay_from_prod;
        logic            look_mod;
        logic            sum_phase;
        logic            look_sum;
        logic            emit_sample;
        logic            emit_zero;
        logic            done;
    } ctrl_word_t;

    typedef struct packed {
        logic silent;
        logic attack;
        logic out_busy;
    } seq_status_t;

    // Program addresses
    localparam logic [PC_W-1:0] ST_CHECK      = 4'd0;
    localparam logic [PC_W-1:0] ST_AGE_MUL    = 4'd1;
    localparam logic [PC_W-1:0] ST_DECAY_MUL  = 4'd2;
    localparam logic [PC_W-1:0] ST_ATTACK_ENV = 4'd3;
    localparam logic [PC_W-1:0] ST_DECAY_UPD  = 4'd4;
    localparam logic [PC_W-1:0] ST_MOD_SINE   = 4'd5;
    localparam logic [PC_W-1:0] ST_DEV_MUL0   = 4'd6;
    localparam logic [PC_W-1:0] ST_DEV_MUL1   = 4'd7;
    localparam logic [PC_W-1:0] ST_PHASE_SUM  = 4'd8;
    localparam logic [PC_W-1:0] ST_CAR_SINE   = 4'd9;
    localparam logic [PC_W-1:0] ST_AMP_MUL0   = 4'd10;
    localparam logic [PC_W-1:0] ST_AMP_MUL1   = 4'd11;
    localparam logic [PC_W-1:0] ST_EMIT       = 4'd12;
    localparam logic [PC_W-1:0] ST_EMIT_ZERO  = 4'd13;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '0;
        unique case (pc)
            ST_CHECK:
            begin
                w.cond   = COND_SILENT;
                w.target = ST_EMIT_ZERO;
            end
            ST_AGE_MUL:
            begin
                w.cond      = COND_ATTACK;
                w.target    = ST_ATTACK_ENV;
                w.mul_sel   = MUL_AGE_STEP;
                w.adv_phase = 1'b1;
            end
            ST_DECAY_MUL:
            begin
                w.cond           = COND_ALWAYS;
                w.target         = ST_DECAY_UPD;
                w.mul_sel        = MUL_DECAY;
                w.env_from_decay = 1'b1;
            end
            ST_ATTACK_ENV:
            begin
                w.cond          = COND_ALWAYS;
                w.target        = ST_MOD_SINE;
                w.env_from_prod = 1'b1;
            end
            ST_DECAY_UPD:  w.decay_from_prod = 1'b1;
            ST_MOD_SINE:   w.look_mod = 1'b1;
            ST_DEV_MUL0:   w.mul_sel = MUL_SIN_INDEX;
            ST_DEV_MUL1:   w.mul_sel = MUL_PROD_ENV;
            ST_PHASE_SUM:  w.sum_phase = 1'b1;
            ST_CAR_SINE:   w.look_sum = 1'b1;
            ST_AMP_MUL0:   w.mul_sel = MUL_SIN_VOL;
            ST_AMP_MUL1:   w.mul_sel = MUL_PROD_ENV;
            ST_EMIT:
            begin
                w.cond        = COND_OUT_BUSY;
                w.target      = ST_EMIT;
                w.emit_sample = 1'b1;
                w.done        = 1'b1;
            end
            ST_EMIT_ZERO:
            begin
                w.cond      = COND_OUT_BUSY;
                w.target    = ST_EMIT_ZERO;
                w.emit_zero = 1'b1;
                w.done      = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Quarter-wave sine, entry j = round(32767 * sin((j + 0.5) * pi / 2^(bits-1)))
    typedef logic [14:0] sine_rom_t [QUARTER_SIZE];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic [63:0]       r;
        logic signed [63:0] sum;
        for (int j = 0; j < QUARTER_SIZE; j++)
        begin
            x    = (64'(2 * j + 1) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    default: term = term / 64'd156;
                endcase
                if ((k % 2) == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = '0;
            r = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767)
                r = 64'd32767;
            rom[j] = r[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[src/fbv_sequencer.sv]
// Microcode sequencer of the FM bass voice: step counter, control ROM and jumps.
// Depends on fbv_pkg for the control word, status group and program addresses.
`default_nettype none

module fbv_sequencer
    import fbv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire seq_status_t status,
    output logic             idle,
    output ctrl_word_t       ctrl
);

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_word_t      word;
    logic            taken;
    logic            hold;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_SILENT:   taken = status.silent;
            COND_ATTACK:   taken = status.attack;
            COND_OUT_BUSY: taken = status.out_busy;
            default:       taken = 1'b0;
        endcase
    end

    // a wait on the output register repeats the step without side effects
    assign hold = (word.cond == COND_OUT_BUSY) && status.out_busy;
    assign ctrl = (busy_reg && !hold) ? word : '0;
    assign idle = !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = ST_CHECK;
            end
        end
        else if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.done)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= ST_CHECK;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

`default_nettype wire

[src/fm_bass_voice.sv]
// Top level of the two-operator FM bass voice: ports, configuration registers,
// voice state and the shared-multiplier datapath. Depends on fbv_pkg, fbv_sequencer.
`default_nettype none

// One input item gives one signed 16-bit sample. An item with action set starts a
// note (latches phase_step, clears both phases, loads note_length, arms the envelope)
// and then produces a sample; outside a note the sample is 0. Each item runs a short
// microprogram over one shared 31x24 multiplier and one sine table port: a silent
// item checks and emits zero; a sounding item takes the attack or decay path, looks up
// the modulator sine, forms the deviation, looks up the carrier sine and scales it by
// volume and envelope. The emit step waits on out_ready while the output register is
// still full. A new item is taken as soon as the program ends, even while the last
// sample waits in the output register. Configuration writes are always accepted and
// must only be issued while the voice is idle.
module fm_bass_voice
    import fbv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [31:0]           phase_step,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [15:0]         sample_out,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [15:0] volume_reg;
    logic [15:0] note_length_reg;
    logic [11:0] attack_length_reg;
    logic [23:0] attack_step_reg;
    logic [23:0] decay_factor_reg;
    logic [15:0] mod_index_reg;
    logic [14:0] clip_level_reg;

    // voice state
    logic [31:0] carrier_phase_reg;
    logic [31:0] modulator_phase_reg;
    logic [31:0] carrier_step_reg;
    logic [15:0] samples_remaining_reg;
    logic [23:0] decay_envelope_reg;

    // datapath
    logic [23:0]        env_reg;
    logic [54:0]        prod_reg;
    logic [14:0]        sin_mag_reg;
    logic               sin_neg_reg;
    logic [31:0]        phase_sum_reg;
    logic signed [15:0] sample_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    ctrl_word_t  ctrl;
    seq_status_t status;
    logic        seq_idle;
    logic        in_xfer;

    logic [15:0]           age;
    logic [30:0]           mul_a;
    logic [23:0]           mul_b;
    logic [54:0]           mul_p;
    logic [31:0]           mod_incr;
    logic [31:0]           look_phase;
    logic [SINE_IDX_W-1:0] look_addr;
    logic [14:0]           look_val;
    logic [14:0]           look_mag;
    logic [31:0]           offset;
    logic [23:0]           attack_env;
    logic [23:0]           decay_env;
    logic [16:0]           amp_mag;
    logic [16:0]           amp_neg;
    logic signed [15:0]    amp_sample;

    assign in_ready   = seq_idle;
    assign in_xfer    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

    assign age = note_length_reg - samples_remaining_reg;

    assign status.silent   = (samples_remaining_reg == 16'd0);
    assign status.attack   = (age < {4'd0, attack_length_reg});
    assign status.out_busy = out_valid_reg && !out_ready;

    fbv_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_xfer),
        .status (status),
        .idle   (seq_idle),
        .ctrl   (ctrl)
    );

    // shared multiplier operands
    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_AGE_STEP:
            begin
                mul_a = 31'(age);
                mul_b = attack_step_reg;
            end
            MUL_DECAY:
            begin
                mul_a = 31'(decay_envelope_reg);
                mul_b = decay_factor_reg;
            end
            MUL_SIN_INDEX:
            begin
                mul_a = 31'(sin_mag_reg);
                mul_b = 24'(mod_index_reg);
            end
            MUL_PROD_ENV:
            begin
                mul_a = prod_reg[30:0];
                mul_b = env_reg;
            end
            MUL_SIN_VOL:
            begin
                mul_a = 31'(sin_mag_reg);
                mul_b = 24'(volume_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign mod_incr = 32'(carrier_step_reg * MOD_RATIO);

    // quarter-wave lookup: mirror the index in odd quadrants, negate in the second half
    assign look_phase = ctrl.look_sum ? phase_sum_reg : modulator_phase_reg;
    assign look_addr  = look_phase[32-SINE_TABLE_BITS +: SINE_IDX_W]
                        ^ {SINE_IDX_W{look_phase[30]}};
    assign look_val   = SINE_ROM[look_addr];
    assign look_mag   = (ctrl.look_sum && (look_val > clip_level_reg)) ? clip_level_reg
                                                                       : look_val;

    assign offset = prod_reg[51:20];

    assign attack_env = (prod_reg > 55'(ENV_ONE)) ? ENV_ONE : prod_reg[23:0];
    assign decay_env  = (prod_reg[54:23] > 32'(ENV_ONE)) ? ENV_ONE : prod_reg[46:23];

    // scale down by 2^38 and saturate
    assign amp_mag = prod_reg[54:38];
    assign amp_neg = 17'd0 - amp_mag;
    always_comb
    begin
        if (sin_neg_reg)
            amp_sample = (amp_mag > 17'd32768) ? 16'sh8000 : signed'(amp_neg[15:0]);
        else
            amp_sample = (amp_mag > 17'd32767) ? 16'sh7FFF : signed'(amp_mag[15:0]);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit_sample || ctrl.emit_zero)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg            <= 16'd16384;
            note_length_reg       <= 16'd11025;
            attack_length_reg     <= 12'd100;
            attack_step_reg       <= 24'd83886;
            decay_factor_reg      <= 24'd8385756;
            mod_index_reg         <= 16'd7823;
            clip_level_reg        <= 15'd26214;
            carrier_phase_reg     <= '0;
            modulator_phase_reg   <= '0;
            carrier_step_reg      <= STEP_55HZ;
            samples_remaining_reg <= '0;
            decay_envelope_reg    <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_VOLUME:        volume_reg        <= cfg_data[15:0];
                    REG_NOTE_LENGTH:   note_length_reg   <= cfg_data[15:0];
                    REG_ATTACK_LENGTH: attack_length_reg <= cfg_data[11:0];
                    REG_ATTACK_STEP:   attack_step_reg   <= cfg_data;
                    REG_DECAY_FACTOR:  decay_factor_reg  <= cfg_data;
                    REG_MOD_INDEX:     mod_index_reg     <= cfg_data[15:0];
                    REG_CLIP_LEVEL:    clip_level_reg    <= cfg_data[14:0];
                    default:
                    begin
                        // drop writes to unknown indexes
                    end
                endcase
            end

            if (in_xfer && action)
            begin
                carrier_step_reg      <= phase_step;
                carrier_phase_reg     <= '0;
                modulator_phase_reg   <= '0;
                samples_remaining_reg <= note_length_reg;
                decay_envelope_reg    <= ENV_ONE;
            end
            else
            begin
                if (ctrl.adv_phase)
                begin
                    carrier_phase_reg   <= carrier_phase_reg + carrier_step_reg;
                    modulator_phase_reg <= modulator_phase_reg + mod_incr;
                end
                if (ctrl.decay_from_prod)
                    decay_envelope_reg <= decay_env;
                if (ctrl.emit_sample)
                    samples_remaining_reg <= samples_remaining_reg - 16'd1;
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != MUL_NONE)
            prod_reg <= mul_p;
        if (ctrl.env_from_prod)
            env_reg <= attack_env;
        if (ctrl.env_from_decay)
            env_reg <= decay_envelope_reg;
        if (ctrl.look_mod || ctrl.look_sum)
        begin
            sin_mag_reg <= look_mag;
            sin_neg_reg <= look_phase[31];
        end
        if (ctrl.sum_phase)
            phase_sum_reg <= sin_neg_reg ? (carrier_phase_reg - offset)
                                         : (carrier_phase_reg + offset);
        if (ctrl.emit_sample)
            sample_reg <= amp_sample;
        if (ctrl.emit_zero)
            sample_reg <= '0;
    end

endmodule

`default_nettype wire

[tb/sv/fbv_sample_checker.sv]
`timescale 1ns / 100ps
// Sample checker for the FM bass voice: watches the item, result and register channels,
// predicts every sample of the voice and compares it with what the block delivers.
// Depends on fbv_pkg for register indexes and sine table geometry.

module fbv_sample_checker
    import fbv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  action,
    input  logic [31:0]           phase_step,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [15:0]    sample_out,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    samples_owed
);

    // register copies
    logic [15:0] volume;
    logic [15:0] note_len;
    logic [11:0] attack_len;
    logic [23:0] attack_step;
    logic [23:0] decay_factor;
    logic [15:0] mod_index;
    logic [14:0] clip_level;

    // voice state
    logic [31:0] car_phase;
    logic [31:0] mod_acc;
    logic [31:0] car_step;
    logic [15:0] remaining;
    logic [23:0] decay_env;
    logic [14:0] quarter_sine [QUARTER_SIZE];

    logic signed [15:0] expected_samples [$];

    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        mismatches   = 0;
        samples_owed = 0;
        // Taylor series up to x^13 in Q30, evaluated at the middle of each table slot
        for (int j = 0; j < QUARTER_SIZE; j++)
        begin
            x    = (64'(2 * j + 1) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 6; k++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 0;
            r = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767)
                r = 64'd32767;
            quarter_sine[j] = 15'(r);
        end
    end

    function automatic int sine_at(input logic [31:0] phase);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [SINE_IDX_W-1:0]      j;
        int                         v;
        idx = phase[31 -: SINE_TABLE_BITS];
        j   = idx[SINE_IDX_W-1:0];
        // mirror the quarter wave on odd quadrants, negate on the second half
        v = idx[SINE_IDX_W] ? quarter_sine[QUARTER_SIZE - 1 - j] : quarter_sine[j];
        return idx[SINE_IDX_W+1] ? -v : v;
    endfunction

    task automatic voice_next_sample(input logic start, input logic [31:0] step,
                                     output logic signed [15:0] result);
        logic [15:0] age;
        logic [23:0] env;
        logic [63:0] prod;
        logic [31:0] offset;
        int          msin;
        int          csin;
        if (start)
        begin
            car_step  = step;
            car_phase = '0;
            mod_acc   = '0;
            remaining = note_len;
            decay_env = ENV_ONE;
        end
        if (remaining == 16'd0)
            result = '0;
        else
        begin
            age = note_len - remaining;
            if (age < 16'(attack_len))
            begin
                prod = 64'(age) * 64'(attack_step);
                env  = (prod > 64'(ENV_ONE)) ? ENV_ONE : prod[23:0];
            end
            else
            begin
                prod      = (64'(decay_env) * 64'(decay_factor)) >> 23;
                env       = decay_env;
                decay_env = (prod > 64'(ENV_ONE)) ? ENV_ONE : prod[23:0];
            end

            car_phase = car_phase + car_step;
            mod_acc   = mod_acc + 32'(MOD_RATIO * car_step);

            msin   = sine_at(mod_acc);
            prod   = 64'(msin < 0 ? -msin : msin) * 64'(mod_index) * 64'(env);
            offset = 32'(prod >> 20);
            if (msin < 0)
                offset = -offset;

            csin = sine_at(car_phase + offset);
            if (csin > int'(clip_level))
                csin = int'(clip_level);
            if (csin < -int'(clip_level))
                csin = -int'(clip_level);

            prod = (64'(csin < 0 ? -csin : csin) * 64'(volume) * 64'(env)) >> 38;
            if (csin < 0)
                result = (prod > 64'd32768) ? 16'sh8000 : -16'(prod);
            else
                result = (prod > 64'd32767) ? 16'sh7FFF : 16'(prod);

            remaining = remaining - 16'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [15:0] predicted;
        if (!rst_n)
        begin
            volume       = 16'd16384;
            note_len     = 16'd11025;
            attack_len   = 12'd100;
            attack_step  = 24'd83886;
            decay_factor = 24'd8385756;
            mod_index    = 16'd7823;
            clip_level   = 15'd26214;
            car_phase    = '0;
            mod_acc      = '0;
            car_step     = STEP_55HZ;
            remaining    = '0;
            decay_env    = '0;
            expected_samples.delete();
        end
        else
        begin
            // retire before predicting: a result never belongs to an item taken this edge
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: sample_out expected none, actual %0d", $time, sample_out);
                end
                else
                begin
                    predicted = expected_samples.pop_front();
                    if (sample_out !== predicted)
                    begin
                        mismatches++;
                        $display("%0t: sample_out expected %0d, actual %0d",
                                 $time, predicted, sample_out);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_VOLUME:        volume       = cfg_data[15:0];
                    REG_NOTE_LENGTH:   note_len     = cfg_data[15:0];
                    REG_ATTACK_LENGTH: attack_len   = cfg_data[11:0];
                    REG_ATTACK_STEP:   attack_step  = cfg_data[23:0];
                    REG_DECAY_FACTOR:  decay_factor = cfg_data[23:0];
                    REG_MOD_INDEX:     mod_index    = cfg_data[15:0];
                    REG_CLIP_LEVEL:    clip_level   = cfg_data[14:0];
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                voice_next_sample(action, phase_step, predicted);
                expected_samples.push_back(predicted);
            end
        end
        samples_owed = expected_samples.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the FM bass voice testbench: clock, reset, item and register stimulus, result
// back-pressure and the verdict. Depends on fbv_pkg, fm_bass_voice, fbv_sample_checker.

module tb_top
    import fbv_pkg::*;
();

    localparam int CLK_HALF = 5;
    // watchdog limit for the run, set with a wide margin
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    localparam int SET_MIN    = 0;
    localparam int SET_MAX    = 1;
    localparam int SET_RANDOM = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [31:0]           phase_step;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [15:0]    sample_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int samples_owed;
    int cycle_count;
    int cur_note_len;
    bit send_gaps;
    bit recv_gaps;
    bit hold_request;

    fm_bass_voice dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .phase_step (phase_step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    fbv_sample_checker sample_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .phase_step   (phase_step),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .samples_owed (samples_owed)
    );

    initial
        clk = 1'b0;

    always #CLK_HALF clk = ~clk;

    task automatic send_item(input bit start, input logic [31:0] step);
        if (send_gaps && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= start;
        phase_step <= step;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // stop offering items and wait until every sample has been delivered
    task automatic drain();
        in_valid <= 1'b0;
        wait (samples_owed == 0);
        @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                        input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        return (junk << width) | value;
    endfunction

    task automatic load_settings(input int mode);
        logic [15:0] len;
        if (mode == SET_MIN)
        begin
            len = 16'd1;
            write_reg(REG_VOLUME, '0);
            write_reg(REG_NOTE_LENGTH, CFG_DATA_W'(len));
            write_reg(REG_ATTACK_LENGTH, '0);
            write_reg(REG_ATTACK_STEP, '0);
            write_reg(REG_DECAY_FACTOR, '0);
            write_reg(REG_MOD_INDEX, '0);
            write_reg(REG_CLIP_LEVEL, '0);
        end
        else if (mode == SET_MAX)
        begin
            len = 16'hFFFF;
            write_reg(REG_VOLUME, 24'hFFFF);
            write_reg(REG_NOTE_LENGTH, CFG_DATA_W'(len));
            write_reg(REG_ATTACK_LENGTH, 24'hFFF);
            write_reg(REG_ATTACK_STEP, 24'hFFFFFF);
            write_reg(REG_DECAY_FACTOR, 24'hFFFFFF);
            write_reg(REG_MOD_INDEX, 24'hFFFF);
            write_reg(REG_CLIP_LEVEL, 24'h7FFF);
        end
        else
        begin
            len = 16'($urandom_range(1, 80));
            // junk above each register's width must be dropped by the block
            write_reg(REG_VOLUME,
                      with_junk(CFG_DATA_W'($urandom_range(0, 32768)), 16));
            write_reg(REG_NOTE_LENGTH, with_junk(CFG_DATA_W'(len), 16));
            write_reg(REG_ATTACK_LENGTH,
                      with_junk(CFG_DATA_W'($urandom_range(0, 24)), 12));
            write_reg(REG_ATTACK_STEP, CFG_DATA_W'($urandom_range(0, 24'h200000)));
            write_reg(REG_DECAY_FACTOR,
                      CFG_DATA_W'($urandom_range(24'h700000, 24'h800000)));
            write_reg(REG_MOD_INDEX,
                      with_junk(CFG_DATA_W'($urandom_range(0, 65535)), 16));
            write_reg(REG_CLIP_LEVEL,
                      with_junk(CFG_DATA_W'($urandom_range(0, 32767)), 15));
        end
        cfg_valid    <= 1'b0;
        cur_note_len = int'(len);
    endtask

    // mostly whole notes (a start, then a run of next-sample items), some loose items
    task automatic play_notes(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(1'($urandom_range(1)), $urandom());
                sent++;
            end
            else
            begin
                send_item(1'b1, ($urandom_range(3) == 0) ? $urandom()
                                                        : $urandom_range(0, 32'h0400_0000));
                sent++;
                run = $urandom_range(0, cur_note_len + 4);
                while (run > 0 && sent < count)
                begin
                    send_item(1'b0, $urandom());
                    sent++;
                    run--;
                end
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            out_ready <= !(recv_gaps && $urandom_range(99) < 10);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fm_bass_voice: mismatch");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = 1'b0;
        phase_step   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_VOLUME;
        cfg_data     = '0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        hold_request = 1'b0;
        cur_note_len = 11025;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // silence before any note, then notes at the phase step extremes
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b1, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h5555_5555);

        // a note of zero length stays silent
        drain();
        write_reg(REG_NOTE_LENGTH, 24'd0);
        cfg_valid <= 1'b0;
        send_item(1'b1, 32'h0123_4567);
        send_item(1'b0, 32'hAAAA_AAAA);

        // no attack: decay from full scale on the first sample
        drain();
        write_reg(REG_NOTE_LENGTH, 24'd40);
        write_reg(REG_ATTACK_LENGTH, 24'd0);
        cfg_valid <= 1'b0;
        send_item(1'b1, 32'h0800_0000);
        repeat (3) send_item(1'b0, $urandom());

        // oversized envelope factors and gain saturate; an unknown index is ignored
        drain();
        write_reg(REG_VOLUME, 24'hFFFF);
        write_reg(REG_ATTACK_LENGTH, 24'd4);
        write_reg(REG_ATTACK_STEP, 24'hFFFFFF);
        write_reg(REG_DECAY_FACTOR, 24'hFFFFFF);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_item(1'b1, 32'h1000_0000);
        repeat (5) send_item(1'b0, $urandom());

        // note length rewritten mid-note: first skip the attack, then restart it
        drain();
        write_reg(REG_NOTE_LENGTH, 24'd50);
        write_reg(REG_VOLUME, 24'd32768);
        write_reg(REG_DECAY_FACTOR, 24'd8385756);
        cfg_valid <= 1'b0;
        send_item(1'b1, 32'h0200_0000);
        repeat (3) send_item(1'b0, $urandom());
        drain();
        write_reg(REG_NOTE_LENGTH, 24'd2);
        cfg_valid <= 1'b0;
        repeat (2) send_item(1'b0, $urandom());
        drain();
        write_reg(REG_NOTE_LENGTH, 24'd60);
        write_reg(REG_ATTACK_LENGTH, 24'd30);
        cfg_valid <= 1'b0;
        repeat (2) send_item(1'b0, $urandom());

        for (int p = 0; p < 8; p++)
        begin
            drain();
            load_settings(p == 0 ? SET_MIN : (p == 1 ? SET_MAX : SET_RANDOM));
            send_gaps = (p != 5);
            recv_gaps = (p != 5);
            // keep offering items while the result side holds off
            if (p == 3)
                hold_request = 1'b1;
            play_notes(p < 2 ? 30 : 64);
        end

        in_valid <= 1'b0;
        wait (samples_owed == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("fm_bass_voice: match");
        else
            $display("fm_bass_voice: mismatch");
        $finish;
    end

endmodule
